### sv/pafb_pkg.sv
// ----------------------------------------------------------------------------
// pafb_pkg
// Types, constants and helpers shared by the paged block allocator modules.
// ----------------------------------------------------------------------------
package pafb_pkg;

  localparam int NUM_PAGES       = 8;
  localparam int BLOCKS_PER_PAGE = 16;
  localparam int PAGE_W  = $clog2(NUM_PAGES);
  localparam int SLOT_W  = $clog2(BLOCKS_PER_PAGE);
  localparam int ADDR_W  = 7;
  localparam int LINK_W  = 5;
  localparam int TOT_W   = 8;
  localparam int PCNT_W  = 4;
  localparam int SEQ_W   = 4;
  localparam int IN_W    = 16;
  localparam int OUT_W   = 40;

  typedef enum logic [2:0] {
    REQ_ALLOC   = 3'd0,
    REQ_FREE    = 3'd1,
    REQ_ADD     = 3'd2,
    REQ_SHRINK  = 3'd3,
    REQ_RELEASE = 3'd4
  } req_code_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_BLOCK = 2'd1,
    ST_BAD_ADDR = 2'd2,
    ST_NO_SLOT  = 2'd3
  } status_code_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_PICK_ALLOC,
    OP_PICK_INACT,
    OP_SET_STATUS,
    OP_FREE,
    OP_FILL_WR,
    OP_ALLOC_RD,
    OP_ALLOC_WR,
    OP_SHRINK_STEP,
    OP_RELEASE,
    OP_PUSH_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t       op;
    logic [SEQ_W-1:0] seq;
    logic         last;
    status_code_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       has_part;
    logic       has_empty;
    logic       has_inact;
    logic       free_ok;
    logic       top_empty;
    logic       above_wm;
    logic       out_free;
  } dp_stat_t;

  function automatic logic [PAGE_W-1:0] lowest_set(input logic [NUM_PAGES-1:0] v);
    logic [PAGE_W-1:0] r;
    logic              found;
    r = '0;
    found = 1'b0;
    for (int i = 0; i < NUM_PAGES; i++) begin
      if (v[i] && !found) begin
        r = PAGE_W'(i);
        found = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [PCNT_W-1:0] count_set(input logic [NUM_PAGES-1:0] v);
    logic [PCNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < NUM_PAGES; i++) begin
      n = n + PCNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

### sv/pafb_ctrl.sv
// ----------------------------------------------------------------------------
// pafb_ctrl
// Request sequencer: decodes each item and steps the datapath through it.
// ----------------------------------------------------------------------------
module pafb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  pafb_pkg::dp_stat_t stat,
  output pafb_pkg::dp_cmd_t  cmd
);
  import pafb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_FILL, S_ALOC_RD, S_ALOC_WR, S_SHRINK, S_DONE
  } state_t;

  state_t           state, state_next;
  logic [SEQ_W-1:0] seq, seq_next;
  logic             fill_last, shrink_last;

  assign s_tready    = (state == S_IDLE);
  assign fill_last   = (seq == SEQ_W'(BLOCKS_PER_PAGE - 1));
  assign shrink_last = (seq == SEQ_W'(NUM_PAGES - 1));

  always_comb begin
    state_next = state;
    seq_next   = seq;
    cmd.op     = OP_NOP;
    cmd.seq    = seq;
    cmd.last   = 1'b0;
    cmd.code   = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = OP_LOAD;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        seq_next   = '0;
        state_next = S_DONE;
        unique case (stat.req)
          REQ_ALLOC: begin
            if (stat.has_part || stat.has_empty) begin
              cmd.op     = OP_PICK_ALLOC;
              state_next = S_ALOC_RD;
            end else if (stat.has_inact) begin
              cmd.op     = OP_PICK_INACT;
              state_next = S_FILL;
            end else begin
              cmd.op   = OP_SET_STATUS;
              cmd.code = ST_NO_BLOCK;
            end
          end
          REQ_FREE: begin
            if (stat.free_ok) begin
              cmd.op = OP_FREE;
            end else begin
              cmd.op   = OP_SET_STATUS;
              cmd.code = ST_BAD_ADDR;
            end
          end
          REQ_ADD: begin
            if (stat.has_inact) begin
              cmd.op     = OP_PICK_INACT;
              state_next = S_FILL;
            end else begin
              cmd.op   = OP_SET_STATUS;
              cmd.code = ST_NO_SLOT;
            end
          end
          REQ_SHRINK:  state_next = S_SHRINK;
          REQ_RELEASE: cmd.op = OP_RELEASE;
          default:     state_next = S_DONE;
        endcase
      end
      S_FILL: begin
        // one link entry per cycle; the last one also activates the page
        cmd.op   = OP_FILL_WR;
        cmd.last = fill_last;
        seq_next = seq + 1'b1;
        if (fill_last) begin
          state_next = (stat.req == REQ_ALLOC) ? S_ALOC_RD : S_DONE;
        end
      end
      S_ALOC_RD: begin
        if (stat.top_empty) begin
          cmd.op     = OP_SET_STATUS;
          cmd.code   = ST_NO_BLOCK;
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_ALLOC_RD;
          state_next = S_ALOC_WR;
        end
      end
      S_ALOC_WR: begin
        cmd.op     = OP_ALLOC_WR;
        state_next = S_DONE;
      end
      S_SHRINK: begin
        if (!stat.above_wm) begin
          state_next = S_DONE;
        end else begin
          cmd.op   = OP_SHRINK_STEP;
          seq_next = seq + 1'b1;
          if (shrink_last) state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op     = OP_PUSH_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      seq   <= '0;
    end else begin
      state <= state_next;
      seq   <= seq_next;
    end
  end

endmodule

### sv/pafb_dp.sv
// ----------------------------------------------------------------------------
// pafb_dp
// Page tables, block link memory, totals and the result register.
// ----------------------------------------------------------------------------
module pafb_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [pafb_pkg::IN_W-1:0]  s_tdata,
  input  logic                       cfg_valid,
  input  logic [pafb_pkg::TOT_W-1:0] cfg_data,
  input  pafb_pkg::dp_cmd_t          cmd,
  output pafb_pkg::dp_stat_t         stat,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [pafb_pkg::OUT_W-1:0] m_tdata
);
  import pafb_pkg::*;

  localparam int DEPTH = NUM_PAGES * BLOCKS_PER_PAGE;

  logic [2:0]          req_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [PAGE_W-1:0]   pick_q;
  status_code_t        status_q;
  logic [ADDR_W-1:0]   granted_q;
  logic [PCNT_W-1:0]   released_q;
  logic [TOT_W-1:0]    wm;
  logic [TOT_W-1:0]    total_free;
  logic [TOT_W-1:0]    total_used;
  logic [NUM_PAGES-1:0] page_active;
  logic [LINK_W-1:0]   used_cnt [NUM_PAGES];
  logic [LINK_W-1:0]   stack_top [NUM_PAGES];
  logic [LINK_W-1:0]   link_mem [DEPTH];
  logic [LINK_W-1:0]   rd_link;

  logic [NUM_PAGES-1:0] part_v, empty_v;
  logic [PAGE_W-1:0]    free_pg, shr_pg;
  logic [SLOT_W-1:0]    free_slot;
  logic [ADDR_W-1:0]    alloc_idx;
  logic [PCNT_W-1:0]    act_cnt;

  always_comb begin
    for (int i = 0; i < NUM_PAGES; i++) begin
      part_v[i]  = page_active[i] && (used_cnt[i] != '0) &&
                   (used_cnt[i] < LINK_W'(BLOCKS_PER_PAGE));
      empty_v[i] = page_active[i] && (used_cnt[i] == '0);
    end
  end

  assign free_pg   = addr_q[ADDR_W-1:SLOT_W];
  assign free_slot = addr_q[SLOT_W-1:0];
  assign shr_pg    = cmd.seq[PAGE_W-1:0];
  assign alloc_idx = {pick_q, stack_top[pick_q][SLOT_W-1:0]};
  assign act_cnt   = count_set(page_active);

  assign stat.req       = req_q;
  assign stat.has_part  = |part_v;
  assign stat.has_empty = |empty_v;
  assign stat.has_inact = ~&page_active;
  assign stat.free_ok   = page_active[free_pg] && (used_cnt[free_pg] != '0);
  assign stat.top_empty = stack_top[pick_q] >= LINK_W'(BLOCKS_PER_PAGE);
  assign stat.above_wm  = total_free > wm;
  assign stat.out_free  = !m_tvalid || m_tready;

  // link memory: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.op == OP_FILL_WR) begin
      link_mem[{pick_q, cmd.seq[SLOT_W-1:0]}] <= LINK_W'(cmd.seq) + 1'b1;
    end else if (cmd.op == OP_FREE) begin
      link_mem[addr_q] <= stack_top[free_pg];
    end
    if (cmd.op == OP_ALLOC_RD) begin
      rd_link <= link_mem[alloc_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wm          <= TOT_W'(16);
      total_free  <= '0;
      total_used  <= '0;
      page_active <= '0;
      m_tvalid    <= 1'b0;
      for (int i = 0; i < NUM_PAGES; i++) begin
        used_cnt[i]  <= '0;
        stack_top[i] <= LINK_W'(BLOCKS_PER_PAGE);
      end
    end else begin
      if (cfg_valid) wm <= cfg_data;
      if (cmd.op == OP_PUSH_OUT) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (cmd.op)
        OP_LOAD: begin
          req_q      <= s_tdata[2:0];
          addr_q     <= s_tdata[3 +: ADDR_W];
          status_q   <= ST_OK;
          granted_q  <= '0;
          released_q <= '0;
        end
        OP_PICK_ALLOC: pick_q <= stat.has_part ? lowest_set(part_v) : lowest_set(empty_v);
        OP_PICK_INACT: pick_q <= lowest_set(~page_active);
        OP_SET_STATUS: status_q <= cmd.code;
        OP_FREE: begin
          stack_top[free_pg] <= LINK_W'(free_slot);
          used_cnt[free_pg]  <= used_cnt[free_pg] - 1'b1;
          total_free         <= total_free + 1'b1;
          total_used         <= total_used - 1'b1;
        end
        OP_FILL_WR: begin
          if (cmd.last) begin
            page_active[pick_q] <= 1'b1;
            used_cnt[pick_q]    <= '0;
            stack_top[pick_q]   <= '0;
            total_free          <= total_free + TOT_W'(BLOCKS_PER_PAGE);
          end
        end
        OP_ALLOC_RD: granted_q <= alloc_idx;
        OP_ALLOC_WR: begin
          stack_top[pick_q] <= (rd_link > LINK_W'(BLOCKS_PER_PAGE)) ?
                               LINK_W'(BLOCKS_PER_PAGE) : rd_link;
          used_cnt[pick_q]  <= used_cnt[pick_q] + 1'b1;
          total_free        <= total_free - 1'b1;
          total_used        <= total_used + 1'b1;
        end
        OP_SHRINK_STEP: begin
          if (empty_v[shr_pg]) begin
            page_active[shr_pg] <= 1'b0;
            used_cnt[shr_pg]    <= '0;
            stack_top[shr_pg]   <= LINK_W'(BLOCKS_PER_PAGE);
            total_free          <= total_free - TOT_W'(BLOCKS_PER_PAGE);
            released_q          <= released_q + 1'b1;
          end
        end
        OP_RELEASE: begin
          released_q  <= act_cnt;
          page_active <= '0;
          total_free  <= '0;
          total_used  <= '0;
          for (int i = 0; i < NUM_PAGES; i++) begin
            used_cnt[i]  <= '0;
            stack_top[i] <= LINK_W'(BLOCKS_PER_PAGE);
          end
        end
        OP_PUSH_OUT: begin
          m_tdata  <= {7'd0, act_cnt, total_used, total_free, released_q,
                       granted_q, status_q};
        end
        OP_NOP: ;
        default: ;
      endcase
    end
  end

endmodule

### sv/paged_fixed_block_allocator.sv
// ----------------------------------------------------------------------------
// paged_fixed_block_allocator
// Fixed-size block allocator over page slots with per-page free stacks.
// ----------------------------------------------------------------------------
// Allocate first activates a page when no active page has a free block; page
// activation (also for add page) writes one link entry per cycle.
// One item at a time; the next is taken once the result sits in the output
// register. Reset (rst, synchronous) empties all pages, watermark to 16.
module paged_fixed_block_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // req_type[2:0], block_addr[9:3]
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[1:0], granted_addr[8:2], pages_released[12:9], free_blocks[20:13],
  // used_blocks[28:21], active_pages[32:29]
  output logic [39:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // free_watermark
);
  import pafb_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  pafb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pafb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
